/* design/assert_macros.svh */
// Assertion macros for the RTL files; ilff_ctrl is the only file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ILFF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ILFF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ILFF_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILFF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* design/ilff_pkg.sv */
package ilff_pkg;

  localparam int HeapWords = 4096;
  localparam int AddrW     = 12;
  localparam int SizeW     = 13;
  localparam int EntryW    = SizeW + 1;
  localparam int BytesW    = 31;

  localparam logic [BytesW-1:0] MaxRequestBytes = 31'd1073741824;
  localparam logic [SizeW-1:0]  MinHeapWords    = 13'd2;
  localparam logic [SizeW-1:0]  MaxHeapWords    = 13'(HeapWords);

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTooLarge = 2'd1,
    StatusNoSpace  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDecode,
    StWalk,
    StSplit,
    StFreeChk,
    StResp
  } state_e;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             alloc;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [BytesW-1:0] request_bytes;
    logic [AddrW-1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [SizeW-1:0] heap_words;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

endpackage

/* design/implicit_list_first_fit_allocator.sv */
// First-fit heap allocator over an implicit list of block headers kept in a single-port
// header memory of 4096 words. After reset and after every heap_words write, a clearing
// pass rewrites all 4096 words, and no item is taken until it ends. An allocate request
// is decoded and then walks the headers first-fit, one header per cycle through the
// memory port; a further state writes the header of a free remainder when one is split
// off. A rejected request is answered from decode, and a free first reads its header.
// Items are handled one at a time; the result sits in an output register.
module implicit_list_first_fit_allocator import ilff_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SizeW-1:0]     cfg_data_i
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  mem_req_t  mem_req;
  entry_t    mem_rdata;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.we = cfg_valid_i;
    if (cfg_data_i < MinHeapWords) begin
      cfg.heap_words = MinHeapWords;
    end else if (cfg_data_i > MaxHeapWords) begin
      cfg.heap_words = MaxHeapWords;
    end else begin
      cfg.heap_words = cfg_data_i;
    end
  end

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  ilff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  ilff_ram #(
    .Width (EntryW),
    .Depth (HeapWords)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

/* design/ilff_ram.sv */
module ilff_ram #(
  parameter int Width = 14,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ilff_ctrl.sv */
`include "assert_macros.svh"

module ilff_ctrl import ilff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o,
  output mem_req_t  mem_req_o,
  input  entry_t    mem_rdata_i
);

  state_e           state_q, state_d;
  logic [SizeW-1:0] hw_q, hw_d;
  logic [SizeW-1:0] used_q, used_d;
  logic [AddrW-1:0] clr_q, clr_d;
  in_item_t         item_q, item_d;
  logic [SizeW-1:0] need_q, need_d;
  logic [AddrW-1:0] h_q, h_d;
  logic [AddrW-1:0] split_addr_q, split_addr_d;
  logic [SizeW-1:0] left_q, left_d;
  out_item_t        res_q, res_d;

  logic [31:0]      round_sum;
  logic [28:0]      payload;
  logic [28:0]      need_w;
  logic [29:0]      space_sum;
  logic             too_large;
  logic             no_space;
  logic [SizeW-1:0] walk_next;
  logic [SizeW-1:0] split_end;
  logic [AddrW-1:0] free_hdr;

  assign round_sum = {1'b0, item_q.request_bytes} + 32'd7;
  assign payload   = (round_sum[31:3] == 29'd0) ? 29'd1 : round_sum[31:3];
  assign need_w    = payload + 29'd1;
  assign space_sum = {1'b0, need_w} + {17'd0, used_q};
  assign too_large = item_q.request_bytes > MaxRequestBytes;
  assign no_space  = space_sum > {17'd0, hw_q};
  assign walk_next = {1'b0, h_q} + mem_rdata_i.size;
  assign split_end = {1'b0, h_q} + need_q;
  assign free_hdr  = item_q.block_addr - 12'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      hw_q    <= MaxHeapWords;
      used_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      hw_q    <= hw_d;
      used_q  <= used_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    need_q       <= need_d;
    h_q          <= h_d;
    split_addr_q <= split_addr_d;
    left_q       <= left_d;
    res_q        <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    hw_d         = hw_q;
    used_d       = used_q;
    clr_d        = clr_q;
    item_d       = item_q;
    need_d       = need_q;
    h_d          = h_q;
    split_addr_d = split_addr_q;
    left_d       = left_q;
    res_d        = res_q;
    mem_req_o    = '0;
    in_ready_o   = (state_q == StIdle);
    res_valid_o  = (state_q == StResp);

    unique case (state_q)
      StClear: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = (clr_q == '0) ? entry_t'{size: hw_q, alloc: 1'b0} : '0;
        clr_d           = clr_q + 12'd1;
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = StDecode;
        end
      end
      StDecode: begin
        res_d = '{addr: '0, status: StatusOk};
        if (item_q.op == OpAlloc) begin
          if (too_large) begin
            res_d.status = StatusTooLarge;
            state_d      = StResp;
          end else if (no_space) begin
            res_d.status = StatusNoSpace;
            state_d      = StResp;
          end else begin
            need_d         = need_w[SizeW-1:0];
            h_d            = '0;
            mem_req_o.addr = '0;
            state_d        = StWalk;
          end
        end else begin
          if (item_q.block_addr == '0 || {1'b0, item_q.block_addr} >= hw_q) begin
            state_d = StResp;
          end else begin
            mem_req_o.addr = free_hdr;
            state_d        = StFreeChk;
          end
        end
      end
      StWalk: begin
        if (mem_rdata_i.size == '0) begin
          res_d   = '{addr: '0, status: StatusNoSpace};
          state_d = StResp;
        end else if (!mem_rdata_i.alloc && mem_rdata_i.size >= need_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = h_q;
          mem_req_o.wdata = '{size: need_q, alloc: 1'b1};
          used_d          = used_q + need_q;
          res_d           = '{addr: h_q + 12'd1, status: StatusOk};
          left_d          = mem_rdata_i.size - need_q;
          split_addr_d    = split_end[AddrW-1:0];
          if (mem_rdata_i.size != need_q && split_end < hw_q) begin
            state_d = StSplit;
          end else begin
            state_d = StResp;
          end
        end else if (walk_next < hw_q) begin
          h_d            = walk_next[AddrW-1:0];
          mem_req_o.addr = walk_next[AddrW-1:0];
        end else begin
          res_d   = '{addr: '0, status: StatusNoSpace};
          state_d = StResp;
        end
      end
      StSplit: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = split_addr_q;
        mem_req_o.wdata = '{size: left_q, alloc: 1'b0};
        state_d         = StResp;
      end
      StFreeChk: begin
        if (mem_rdata_i.alloc) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = free_hdr;
          mem_req_o.wdata = '{size: mem_rdata_i.size, alloc: 1'b0};
          used_d          = (mem_rdata_i.size > used_q) ? '0 : used_q - mem_rdata_i.size;
        end
        state_d = StResp;
      end
      StResp: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
        clr_d   = '0;
      end
    endcase

    if (cfg_i.we) begin
      hw_d    = cfg_i.heap_words;
      used_d  = '0;
      clr_d   = '0;
      state_d = StClear;
    end
  end

  assign res_o = res_q;

  `ILFF_ASSERT(a_used_in_heap, clk_i, rst_ni, used_q <= hw_q, "used count exceeds heap")
  `ILFF_ASSERT(a_walk_in_heap, clk_i, rst_ni, state_q == StWalk |-> h_q < hw_q,
               "walk beyond heap end")
  `ILFF_ASSERT(a_cfg_clears, clk_i, rst_ni, cfg_i.we |=> state_q == StClear,
               "configuration write did not start clearing")
  `ILFF_ASSERT(a_split_after_walk, clk_i, rst_ni,
               state_q == StSplit |-> $past(state_q) == StWalk, "split without a fit")

endmodule

/* tb/tb.sv */
module tb import ilff_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  class heap_shadow;
    entry_t                  headers [HeapWords];
    logic [SizeW-1:0]        heap_limit;
    logic [SizeW-1:0]        used_words;
    out_item_t               awaited_replies [$];
    logic [AddrW-1:0]        live_blocks [$];
    logic [AddrW-1:0]        freed_blocks [$];
    int                      mismatches;

    function void init_heap(logic [SizeW-1:0] words);
      if (words < MinHeapWords) begin
        heap_limit = MinHeapWords;
      end else if (words > MaxHeapWords) begin
        heap_limit = MaxHeapWords;
      end else begin
        heap_limit = words;
      end
      foreach (headers[i]) headers[i] = '0;
      headers[0] = '{size: heap_limit, alloc: 1'b0};
      used_words = '0;
      live_blocks.delete();
      freed_blocks.delete();
    endfunction

    function void note_request(in_item_t req);
      out_item_t       reply;
      longint unsigned payload;
      longint unsigned need;
      int              h;
      int              sz;
      reply.addr   = '0;
      reply.status = StatusOk;
      if (req.op == OpAlloc) begin
        if (req.request_bytes > MaxRequestBytes) begin
          reply.status = StatusTooLarge;
        end else begin
          payload = (longint'(req.request_bytes) + 7) / 8;
          if (payload == 0) payload = 1;
          need = payload + 1;
          reply.status = StatusNoSpace;
          if (need + used_words <= heap_limit) begin
            h = 0;
            while (h < heap_limit) begin
              sz = headers[h].size;
              if (sz == 0) break;
              if (!headers[h].alloc && sz >= need) begin
                headers[h] = '{size: SizeW'(need), alloc: 1'b1};
                if (sz > need && h + need < heap_limit) begin
                  headers[h + need] = '{size: SizeW'(sz - need), alloc: 1'b0};
                end
                used_words   = used_words + SizeW'(need);
                reply.addr   = AddrW'(h + 1);
                reply.status = StatusOk;
                live_blocks.push_back(reply.addr);
                break;
              end
              h += sz;
            end
          end
        end
      end else if (req.block_addr != 0 && req.block_addr < heap_limit) begin
        h = req.block_addr - 1;
        if (headers[h].alloc) begin
          sz = headers[h].size;
          headers[h].alloc = 1'b0;
          used_words = (sz > used_words) ? '0 : used_words - SizeW'(sz);
          for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == req.block_addr) begin
              live_blocks.delete(i);
              break;
            end
          end
          freed_blocks.push_back(req.block_addr);
          if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
        end
      end
      awaited_replies.push_back(reply);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (awaited_replies.size() == 0) begin
        $error("unexpected transfer: addr %0d status %0d", got.addr, got.status);
        mismatches++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.addr !== want.addr) begin
        $error("addr: expected %0d, actual %0d", want.addr, got.addr);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i  = '0;

  heap_shadow       model;
  int               requests_sent = 0;
  int               send_idle_pct = 18;
  int               recv_idle_pct = 81;

  logic [SizeW-1:0] phase_words [12] = '{13'd0, 13'd16, 13'd8191, 13'd3, 13'd40, 13'd1,
                                         13'd100, 13'd4096, 13'd255, 13'd4097, 13'd64,
                                         13'd9};
  int               phase_items [12] = '{60, 120, 80, 60, 150, 40, 200, 60, 200, 60, 200,
                                         170};

  implicit_list_first_fit_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) model.check_reply(out_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(in_item_t req);
    if (requests_sent < 490) begin
      send_idle_pct = 18;
      recv_idle_pct = 81;
    end else if (requests_sent < 960) begin
      send_idle_pct = 81;
      recv_idle_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    model.note_request(req);
    requests_sent++;
  endtask

  task automatic alloc_bytes(logic [BytesW-1:0] bytes);
    in_item_t req;
    req.op            = OpAlloc;
    req.request_bytes = bytes;
    req.block_addr    = AddrW'($urandom);
    send_request(req);
  endtask

  task automatic free_block(logic [AddrW-1:0] addr);
    in_item_t req;
    req.op            = OpFree;
    req.request_bytes = BytesW'($urandom);
    req.block_addr    = addr;
    send_request(req);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_heap_words(logic [SizeW-1:0] words);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= words;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model.init_heap(words);
  endtask

  initial begin
    int               pick;
    int               kind;
    logic [SizeW-1:0] hs;
    model = new();
    model.init_heap(MaxHeapWords);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The heap after reset: rounding, both rejections, ignored and double frees,
    // reuse of a hole, an exact fit at the heap end and a fragmented refusal.
    alloc_bytes(31'd0);
    alloc_bytes(31'd1);
    alloc_bytes(31'd8);
    alloc_bytes(31'd9);
    alloc_bytes(MaxRequestBytes);
    alloc_bytes(MaxRequestBytes + 31'd1);
    alloc_bytes(31'h7FFF_FFFF);
    free_block(12'd0);
    free_block(12'd4095);
    free_block(12'd3);
    free_block(12'd3);
    free_block(12'd2);
    alloc_bytes(31'd8);
    alloc_bytes(31'd32688);
    alloc_bytes(31'd0);
    free_block(12'd10);
    free_block(12'd1);
    alloc_bytes(31'd32696);
    alloc_bytes(31'd32680);
    alloc_bytes(31'd0);
    free_block(12'd3);
    alloc_bytes(31'd9);

    for (int p = 0; p < 12; p++) begin
      wait_drained();
      write_heap_words(phase_words[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        hs   = model.heap_limit;
        pick = $urandom_range(99);
        kind = $urandom_range(99);
        if (pick < 40 && model.live_blocks.size() != 0) begin
          free_block(model.live_blocks[$urandom_range(model.live_blocks.size() - 1)]);
        end else if (pick < 46 && model.freed_blocks.size() != 0) begin
          free_block(model.freed_blocks[$urandom_range(model.freed_blocks.size() - 1)]);
        end else if (pick < 54) begin
          free_block((kind < 50) ? AddrW'($urandom_range(hs)) : AddrW'($urandom));
        end else if (kind < 5) begin
          alloc_bytes(MaxRequestBytes + 31'd1 + BytesW'($urandom_range(32'h3FFF_FFFE)));
        end else if (kind < 8) begin
          alloc_bytes(MaxRequestBytes);
        end else if (kind < 20) begin
          alloc_bytes(BytesW'($urandom_range(8 * hs)));
        end else if (kind < 50) begin
          alloc_bytes(BytesW'($urandom_range(24)));
        end else begin
          alloc_bytes(BytesW'($urandom_range(8 * ((hs + 5) / 6))));
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("** implicit_list_first_fit_allocator: PASSED **");
    end else begin
      $display("** implicit_list_first_fit_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("** implicit_list_first_fit_allocator: FAILED **");
    $finish;
  end

endmodule
